FILE: rtl/jal_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jal_pkg;

  // Configuration register map (byte addresses)
  localparam int unsigned RegAddrWidth = 3;
  localparam logic [RegAddrWidth-1:0] RegMaxAccel = 3'd0;

  localparam int unsigned AccelWidth = 15;
  localparam logic [AccelWidth-1:0] AccelReset = 15'd64;

  localparam int unsigned StiffWidth = 7;

  localparam int unsigned ApbDataWidth = 32;

endpackage

`default_nettype wire

FILE: rtl/joint_acceleration_limiter.sv
`timescale 1ns / 1ps
`default_nettype none

// Joint acceleration limiter. One joint setpoint per beat on the slave stream, one limited
// setpoint per beat on the master stream, in order. The block takes a beat in every clock
// cycle unless the master stream stalls; a beat passes the input register, then the result
// register. Each result updates a two-entry angle history that the next beat reads, in the
// same edge that loads the result register, so consecutive beats never wait on each other.
// A switched-off joint or zero stiffness returns the measured angle with stiffness 0. Until
// two results are stored, or while get-up runs, the target passes unchanged. Otherwise a
// growing or reversing speed change is clamped to max_accel_per_cycle (APB byte address 0,
// reset 64) and the angle saturates. Write the register only while the stream is idle.
module joint_acceleration_limiter #(
  parameter int unsigned ANGLE_WIDTH = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,

  input  wire logic                                  s_axis_tvalid,
  output      logic                                  s_axis_tready,
  // target_angle, angle_off, stiffness_in, measured_angle, getup_active, zero pad
  input  wire logic [((2*ANGLE_WIDTH+9+7)/8)*8-1:0]  s_axis_tdata,

  output      logic                                  m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // out_angle, out_stiffness, zero pad
  output      logic [((ANGLE_WIDTH+7+7)/8)*8-1:0]    m_axis_tdata,

  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [jal_pkg::RegAddrWidth-1:0]      paddr,
  input  wire logic [jal_pkg::ApbDataWidth-1:0]      pwdata,
  output      logic [jal_pkg::ApbDataWidth-1:0]      prdata,
  output      logic                                  pready
);

  localparam int unsigned W  = ANGLE_WIDTH;
  localparam int unsigned SW = jal_pkg::StiffWidth;
  localparam int unsigned AW = jal_pkg::AccelWidth;
  // Working width for speeds, speed differences and the unsaturated sum
  localparam int unsigned CW = ((W > AW + 1) ? W : AW + 1) + 4;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [AW-1:0] max_accel_q, max_accel_d;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == jal_pkg::RegMaxAccel);

  always_comb begin
    max_accel_d = max_accel_q;
    if (cfg_wr) begin
      max_accel_d = pwdata[AW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == jal_pkg::RegMaxAccel) begin
      prdata[AW-1:0] = max_accel_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_accel_q <= jal_pkg::AccelReset;
    end else begin
      max_accel_q <= max_accel_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: input register feeds result register
  // ---------------------------------------------------------------------------
  logic in_valid_q;
  logic out_valid_q;
  logic out_free;
  logic advance;
  logic in_load;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_load       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Input register (payload only)
  logic signed [W-1:0]  target_q;
  logic                 off_q;
  logic [SW-1:0]        stiff_q;
  logic signed [W-1:0]  measured_q;
  logic                 getup_q;

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      target_q   <= s_axis_tdata[W-1:0];
      off_q      <= s_axis_tdata[W];
      stiff_q    <= s_axis_tdata[W+SW:W+1];
      measured_q <= s_axis_tdata[2*W+SW:W+SW+1];
      getup_q    <= s_axis_tdata[2*W+SW+1];
    end
  end

  // ---------------------------------------------------------------------------
  // History
  // ---------------------------------------------------------------------------
  logic signed [W-1:0] newest_q;
  logic signed [W-1:0] older_q;
  logic [1:0]          fill_q;

  // ---------------------------------------------------------------------------
  // Limiter datapath
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] acc;
  logic signed [CW-1:0] old_speed;
  logic signed [CW-1:0] new_speed;
  logic signed [CW-1:0] speed_diff;
  logic signed [CW-1:0] old_mag;
  logic signed [CW-1:0] new_mag;
  logic signed [CW-1:0] clamped_speed;
  logic signed [CW-1:0] sum;
  logic signed [CW-1:0] angle_max;
  logic signed [CW-1:0] angle_min;
  logic                 reversal;
  logic                 joint_off;
  logic                 limit_en;
  logic signed [W-1:0]  result;
  logic [SW-1:0]        stiff_out;

  assign acc       = CW'(signed'({1'b0, max_accel_q}));
  assign old_speed = CW'(newest_q) - CW'(older_q);
  assign new_speed = CW'(target_q) - CW'(newest_q);
  assign speed_diff = new_speed - old_speed;
  assign old_mag   = old_speed[CW-1] ? -old_speed : old_speed;
  assign new_mag   = new_speed[CW-1] ? -new_speed : new_speed;
  assign angle_max = CW'(signed'({1'b0, {(W-1){1'b1}}}));
  assign angle_min = -angle_max - CW'(signed'(2'sb01));

  // Opposite nonzero signs
  assign reversal = (old_speed > 0 && new_speed < 0) || (old_speed < 0 && new_speed > 0);
  assign joint_off = off_q || (stiff_q == '0);
  assign limit_en  = (fill_q == 2'd2) && !getup_q;

  always_comb begin
    if (speed_diff > acc) begin
      clamped_speed = old_speed + acc;
    end else if (speed_diff < -acc) begin
      clamped_speed = old_speed - acc;
    end else begin
      clamped_speed = new_speed;
    end
    sum = CW'(newest_q) + clamped_speed;
  end

  always_comb begin
    result    = target_q;
    stiff_out = stiff_q;
    if (joint_off) begin
      result    = measured_q;
      stiff_out = '0;
    end else if (limit_en) begin
      if (reversal && (old_mag > acc)) begin
        result = newest_q;
      end else if ((new_mag > old_mag) || reversal) begin
        if (sum > angle_max) begin
          result = angle_max[W-1:0];
        end else if (sum < angle_min) begin
          result = angle_min[W-1:0];
        end else begin
          result = sum[W-1:0];
        end
      end
    end
  end

  // History advances with the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      newest_q <= '0;
      older_q  <= '0;
      fill_q   <= 2'd0;
    end else if (advance) begin
      older_q  <= newest_q;
      newest_q <= result;
      if (fill_q != 2'd2) begin
        fill_q <= fill_q + 2'd1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic signed [W-1:0] out_angle_q;
  logic [SW-1:0]       out_stiff_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_angle_q <= result;
      out_stiff_q <= stiff_out;
    end
  end

  always_comb begin
    m_axis_tdata            = '0;
    m_axis_tdata[W-1:0]     = out_angle_q;
    m_axis_tdata[W+SW-1:W]  = out_stiff_q;
  end

endmodule

`default_nettype wire
